FILE: design/mps_pkg.sv
// Package for the memory pattern search core: transaction types, configuration
// record, mode and register index codes. No dependencies.
`default_nettype none

package mps_pkg;

	localparam int unsigned REG_PATTERN_BYTES = 16;
	localparam int unsigned LEN_W             = 5;
	localparam int unsigned OFFSET_W          = 32;
	localparam int unsigned CFG_DATA_W        = 64;
	localparam int unsigned CFG_IDX_W         = 3;

	typedef enum logic [1:0] {
		MODE_ANY   = 2'd0,
		MODE_WORD4 = 2'd1,
		MODE_WORD8 = 2'd2,
		MODE_WORD16 = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEARCH_MODE  = 3'd0,
		REG_PATTERN_LEN  = 3'd1,
		REG_PATTERN_LOW  = 3'd2,
		REG_PATTERN_HIGH = 3'd3,
		REG_BASE_ADDRESS = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] match_offset;
		logic [OFFSET_W-1:0] match_address;
	} out_item_t;

	typedef struct packed {
		mode_t               search_mode;
		logic [LEN_W-1:0]    pattern_len;
		logic [63:0]         pattern_low;
		logic [63:0]         pattern_high;
		logic [OFFSET_W-1:0] base_address;
	} cfg_t;

endpackage

`default_nettype wire

FILE: design/mps_in_reg.sv
// Input stage of the pattern search: registers one byte transaction and
// raises stall while it cannot move on. Depends on mps_pkg.
`default_nettype none

module mps_in_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             byte_valid,
	output logic                  byte_stall,
	input  wire mps_pkg::in_item_t byte_item,
	input  wire logic             advance,
	output logic                  valid_s1,
	output mps_pkg::in_item_t     item_s1
);
	import mps_pkg::*;

	logic load;

	assign byte_stall = valid_s1 && !advance;
	assign load       = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= byte_item;
		end
	end

endmodule

`default_nettype wire

FILE: design/mps_match.sv
// Window, byte count and match logic of the pattern search: shifts a byte in,
// compares every pattern length in parallel and forms the result. Depends on mps_pkg.
`default_nettype none

module mps_match #(
	parameter int unsigned MAX_PATTERN = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire mps_pkg::in_item_t item_s1,
	input  wire mps_pkg::cfg_t     cfg,
	output logic                   res_valid,
	output mps_pkg::out_item_t     res
);
	import mps_pkg::*;

	localparam int unsigned FILL_W = $clog2(MAX_PATTERN + 1);
	localparam int unsigned CMP_W  = (FILL_W > LEN_W) ? FILL_W : LEN_W;

	logic [7:0]          window_q [MAX_PATTERN];
	logic [7:0]          win_next [MAX_PATTERN];
	logic [FILL_W-1:0]   fill_q;
	logic [FILL_W-1:0]   fill_next;
	logic [OFFSET_W-1:0] count_q;
	logic                done_q;

	logic [8*REG_PATTERN_BYTES-1:0] pat_all;
	logic [LEN_W-1:0]    len_eff;
	logic [REG_PATTERN_BYTES:0] match_by_len;
	logic [OFFSET_W-1:0] start;
	logic [OFFSET_W-1:0] start_sel;
	logic                even_ok;
	logic                fill_ok;
	logic                hit;

	assign pat_all = {cfg.pattern_high, cfg.pattern_low};

	always_comb begin
		win_next[0] = item_s1.data_byte;
		for (int j = 1; j < MAX_PATTERN; j++) begin
			win_next[j] = window_q[j-1];
		end
	end

	assign fill_next = (fill_q == FILL_W'(MAX_PATTERN)) ? fill_q : fill_q + FILL_W'(1);

	always_comb begin
		case (cfg.search_mode)
			MODE_ANY: begin
				len_eff = (cfg.pattern_len > LEN_W'(REG_PATTERN_BYTES)) ?
					LEN_W'(REG_PATTERN_BYTES) : cfg.pattern_len;
			end
			MODE_WORD4:  len_eff = LEN_W'(4);
			MODE_WORD8:  len_eff = LEN_W'(8);
			MODE_WORD16: len_eff = LEN_W'(16);
			default:     len_eff = LEN_W'(16);
		endcase
	end

	// one comparator row per pattern length; the newest byte meets the pattern's last byte
	assign match_by_len[0] = 1'b1;
	for (genvar L = 1; L <= REG_PATTERN_BYTES; L++) begin : g_len
		if (L <= MAX_PATTERN) begin : g_fits
			always_comb begin
				match_by_len[L] = 1'b1;
				for (int k = 0; k < L; k++) begin
					if (win_next[L-1-k] != pat_all[8*k +: 8]) begin
						match_by_len[L] = 1'b0;
					end
				end
			end
		end else begin : g_too_long
			assign match_by_len[L] = 1'b0;
		end
	end

	assign start     = count_q + OFFSET_W'(1) - OFFSET_W'(len_eff);
	assign start_sel = (len_eff == '0) ? count_q : start;
	assign even_ok   = (cfg.search_mode == MODE_ANY) || !start[0];
	assign fill_ok   = CMP_W'(fill_next) >= CMP_W'(len_eff);
	assign hit       = (len_eff == '0) || (fill_ok && even_ok && match_by_len[len_eff]);

	assign res_valid         = !done_q && (hit || item_s1.last_byte);
	assign res.found         = hit;
	assign res.match_offset  = hit ? start_sel : '0;
	assign res.match_address = hit ? cfg.base_address + start_sel : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else if (take) begin
			if (item_s1.last_byte) begin
				fill_q  <= '0;
				count_q <= '0;
				done_q  <= 1'b0;
			end else begin
				fill_q  <= fill_next;
				count_q <= count_q + OFFSET_W'(1);
				done_q  <= done_q || hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				window_q[j] <= win_next[j];
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/mps_out_reg.sv
// Result register of the pattern search: holds one result transaction until
// the receiver takes it. Depends on mps_pkg.
`default_nettype none

module mps_out_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire logic               res_valid,
	input  wire mps_pkg::out_item_t res,
	output logic                    free,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output mps_pkg::out_item_t      result_item
);
	import mps_pkg::*;

	assign free = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (free) begin
			result_valid <= take && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && take && res_valid) begin
			result_item <= res;
		end
	end

endmodule

`default_nettype wire

FILE: design/memory_pattern_search_core.sv
// Top level of the memory pattern search core: configuration registers and the
// input, match and result stages. Depends on mps_pkg, mps_in_reg, mps_match, mps_out_reg.
`default_nettype none

// Streams a memory region one byte per transaction, offset 0 first, and reports
// the first place where the configured pattern lies wholly inside the region.
// Mode 0 matches pattern_len bytes (0 matches at once, above 16 counts as 16)
// at any offset; modes 1, 2 and 3 match 4, 8 or 16 bytes at even offsets only.
// Each region gives exactly one result: found with offset and base plus offset
// at the byte that completes the first match, or found cleared with zeros at the
// byte flagged last_byte; later bytes of a matched region give nothing. The core
// takes one byte every cycle while byte_stall is low: the byte is registered,
// compared against all pattern lengths at once in a single stage, and its result
// is written into the result register as the byte moves on. Stall on the byte side only rises
// while a result is held waiting and another byte is pending. Configuration is
// written through cfg_we/cfg_index/cfg_data while no transaction is in flight.
module memory_pattern_search_core #(
	parameter int unsigned MAX_PATTERN = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [mps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                         byte_valid,
	output logic                              byte_stall,
	input  wire mps_pkg::in_item_t            byte_item,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output mps_pkg::out_item_t                result_item
);
	import mps_pkg::*;

	cfg_t      cfg_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      advance;
	logic      take;
	logic      res_valid;
	out_item_t res;

	// Configuration registers; writes beyond the list drop silently
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.search_mode  <= MODE_ANY;
			cfg_q.pattern_len  <= LEN_W'(1);
			cfg_q.pattern_low  <= '0;
			cfg_q.pattern_high <= '0;
			cfg_q.base_address <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEARCH_MODE:  cfg_q.search_mode  <= mode_t'(cfg_data[1:0]);
				REG_PATTERN_LEN:  cfg_q.pattern_len  <= cfg_data[LEN_W-1:0];
				REG_PATTERN_LOW:  cfg_q.pattern_low  <= cfg_data[63:0];
				REG_PATTERN_HIGH: cfg_q.pattern_high <= cfg_data[63:0];
				REG_BASE_ADDRESS: cfg_q.base_address <= cfg_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// The registered byte moves on whenever the result register has room
	assign take = valid_s1 && advance;

	mps_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	mps_match #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item_s1   (item_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	mps_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.res_valid    (res_valid),
		.res          (res),
		.free         (advance),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

`ifndef SYNTHESIS
	// A miss reports zero offset and zero address
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_item.found |->
			result_item.match_offset == '0 && result_item.match_address == '0)
		else $error("miss result carries a non-zero offset or address");

	// Byte-side stall only comes from a result held by the receiver
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> result_valid && result_stall && valid_s1)
		else $error("byte stall without back-pressure on the result side");

	// An empty input stage with room in the result register leaves the result register empty
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !take |=> !result_valid)
		else $error("result register filled without a transaction");
`endif

endmodule

`default_nettype wire
